>>> rtl/slti_pkg.sv
`default_nettype none

package slti_pkg;

    // table geometry and field widths
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FRAC_W        = 16;
    localparam int PHASE_W       = 32;
    localparam int SAMPLE_W      = 16;
    localparam int CODE_W        = 16;
    localparam int INC_W         = 24;
    localparam int SPAN_PROD_W   = INC_W + CODE_W;

    // queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    // configuration register map
    localparam int CFG_ADDR_W    = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_INC_MIN  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_INC_SPAN = 1'b1;

    localparam logic [INC_W-1:0] INC_MIN_RESET  = 24'd895;
    localparam logic [INC_W-1:0] INC_SPAN_RESET = 24'd893890;

    // fixed-point constants for the table build
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic [CODE_W-1:0] rate_code;
        logic [CODE_W-1:0] depth;
        logic              block_end;
    } slti_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lfo_sample;
        logic                       block_end_out;
    } slti_out_t;

    // one classified tick waiting for the back end
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
        logic [CODE_W-1:0] depth;
        logic              block_end;
    } slti_job_t;

    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_ENTRIES];

    // one table entry: quarter-wave fold, q30 taylor series, round to q15
    function automatic logic signed [SAMPLE_W-1:0] build_entry(int unsigned k);
        logic [63:0] p64;
        logic [31:0] p;
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        p64  = (64'(k) << 32) / 64'(TABLE_ENTRIES);
        p    = p64[31:0];
        quad = p[31:30];
        r    = {34'd0, p[29:0]};
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        z  = (r * Q30_HALF_PI) >> 30;
        z2 = (z * z) >> 30;
        t  = Q30_ONE - z2 / 64'd110;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd6;
        s  = (z * t) >> 30;
        v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad[1] ? -v[SAMPLE_W-1:0] : v[SAMPLE_W-1:0];
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t rom;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            rom[k] = build_entry(32'(k));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

>>> rtl/slti_queue.sv
`default_nettype none

module slti_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire slti_pkg::slti_job_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output slti_pkg::slti_job_t     pop_data,
    output logic                    empty
);
    import slti_pkg::*;

    slti_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + 1'b1;
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/slti_front.sv
`default_nettype none

module slti_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire slti_pkg::slti_in_t                 s_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [slti_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [slti_pkg::INC_W-1:0]         cfg_wdata,
    output logic                                    push,
    output slti_pkg::slti_job_t                     push_data,
    input  wire logic                               full
);
    import slti_pkg::*;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_ADV
    } front_state_t;

    front_state_t             state_reg;
    slti_in_t                 item_reg;
    logic [SPAN_PROD_W-1:0]   span_prod_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [INC_W-1:0]         inc_min_reg;
    logic [INC_W-1:0]         inc_span_reg;

    logic [INC_W:0]           inc;
    logic [PHASE_W-1:0]       phase_next;

    // increment and advanced phase
    assign inc        = {1'b0, inc_min_reg} + {1'b0, span_prod_reg[SPAN_PROD_W-1 -: INC_W]};
    assign phase_next = phase_reg + PHASE_W'(inc);

    assign s_ready = (state_reg == FR_IDLE);
    assign push    = (state_reg == FR_ADV) && !full;

    // job: table index and fraction from the advanced phase
    always_comb begin
        push_data.idx       = phase_next[PHASE_W-1 -: IDX_W];
        push_data.frac      = phase_next[PHASE_W-1-IDX_W -: FRAC_W];
        push_data.depth     = item_reg.depth;
        push_data.block_end = item_reg.block_end;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_min_reg  <= INC_MIN_RESET;
            inc_span_reg <= INC_SPAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_INC_MIN:  inc_min_reg  <= cfg_wdata;
                REG_INC_SPAN: inc_span_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // accept, scale the rate, advance the phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            phase_reg <= '0;
        end else begin
            unique case (state_reg)
                FR_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= FR_MUL;
                    end
                end
                FR_MUL: begin
                    span_prod_reg <= SPAN_PROD_W'(inc_span_reg)
                                     * SPAN_PROD_W'(item_reg.rate_code);
                    state_reg     <= FR_ADV;
                end
                FR_ADV: begin
                    if (!full) begin
                        phase_reg <= phase_next;
                        state_reg <= FR_IDLE;
                    end
                end
                default: state_reg <= FR_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/slti_back.sv
`default_nettype none

module slti_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    output logic                     pop,
    input  wire slti_pkg::slti_job_t pop_data,
    input  wire logic                empty,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output slti_pkg::slti_out_t      m_data
);
    import slti_pkg::*;

    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int INTERP_W = 2 * DIFF_W;
    localparam int PROD_W   = INTERP_W + CODE_W + 1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD_B,
        BK_MIX,
        BK_SCALE
    } back_state_t;

    back_state_t                 state_reg;
    slti_job_t                   job_reg;
    logic signed [SAMPLE_W-1:0]  a_reg;
    logic signed [SAMPLE_W-1:0]  b_reg;
    logic signed [INTERP_W-1:0]  interp_reg;
    logic                        m_valid_reg;
    slti_out_t                   m_data_reg;

    logic [IDX_W-1:0]            nxt_idx;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [DIFF_W-1:0]    frac_s;
    logic signed [DIFF_W-1:0]    depth_s;
    logic signed [INTERP_W-1:0]  a_shift;
    logic signed [INTERP_W-1:0]  diff_prod;
    logic signed [PROD_W-1:0]    prod;
    logic                        out_free;
    logic                        out_load;

    assign pop      = (state_reg == BK_IDLE) && !empty;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == BK_SCALE) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // neighbor entry wraps to zero at the end of the table
    assign nxt_idx = IDX_W'(job_reg.idx + 1'b1);

    // linear interpolation, q15 scaled by 2^16
    assign diff      = {b_reg[SAMPLE_W-1], b_reg} - {a_reg[SAMPLE_W-1], a_reg};
    assign frac_s    = {1'b0, job_reg.frac};
    assign diff_prod = INTERP_W'(diff) * INTERP_W'(frac_s);
    assign a_shift   = {{(INTERP_W-SAMPLE_W-FRAC_W){a_reg[SAMPLE_W-1]}}, a_reg, {FRAC_W{1'b0}}};

    // depth gain, floor by 2^32 through the bit select
    assign depth_s = {1'b0, job_reg.depth};
    assign prod    = PROD_W'(interp_reg) * PROD_W'(depth_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // output register loads a result or drains on a transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                BK_IDLE: begin
                    if (!empty) begin
                        job_reg   <= pop_data;
                        a_reg     <= SINE_ROM[pop_data.idx];
                        state_reg <= BK_RD_B;
                    end
                end
                BK_RD_B: begin
                    b_reg     <= SINE_ROM[nxt_idx];
                    state_reg <= BK_MIX;
                end
                BK_MIX: begin
                    interp_reg <= a_shift + diff_prod;
                    state_reg  <= BK_SCALE;
                end
                BK_SCALE: begin
                    if (out_free) begin
                        m_data_reg.lfo_sample    <= prod[2*FRAC_W +: SAMPLE_W];
                        m_data_reg.block_end_out <= job_reg.block_end;
                        state_reg                <= BK_IDLE;
                    end
                end
                default: state_reg <= BK_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/sine_lfo_table_interp_top.sv
`default_nettype none

// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   rate_code, depth, block_end
// m_        out        m_valid / m_ready   lfo_sample, block_end_out
// cfg_      in         cfg_wr_en           cfg_addr, cfg_wdata (no read-back)
//
// the front accepts a tick, multiplies the rate, then adds the phase;
// the back does two sine rom reads, interpolates, then scales; neither takes
// a new tick before the last has left it, so the back sets the sustained rate
// a two-entry queue lets the front run ahead while the output register stalls
// synchronous active-low reset clears phase, queue and both state machines;
// increment registers return to their default values

module sine_lfo_table_interp_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire slti_pkg::slti_in_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output slti_pkg::slti_out_t                     m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [slti_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [slti_pkg::INC_W-1:0]         cfg_wdata
);
    import slti_pkg::*;

    logic      push;
    slti_job_t push_data;
    logic      full;
    logic      pop;
    slti_job_t pop_data;
    logic      empty;

    // phase accumulation and job classification
    slti_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // decoupling queue
    slti_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // table lookup, interpolation and gain
    slti_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
